[src/bgtr_pkg.sv]
// Shared types, constants and helpers for the bitmap glyph text renderer.
// Used by every module under src; no dependencies of its own.
`default_nettype none

package bgtr_pkg;

    localparam int GLYPH_ROWS  = 16;
    localparam int GLYPH_COLS  = 8;
    localparam int CHAR_COUNT  = 256;
    localparam int STORE_DEPTH = CHAR_COUNT * GLYPH_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROW_W       = $clog2(GLYPH_ROWS + 1);
    localparam int PADDR_W     = 5;
    localparam int LIN_W       = 30;

    localparam logic [7:0]  CODE_NEWLINE = 8'd10;
    localparam logic [7:0]  CODE_TAB     = 8'd9;
    localparam logic [16:0] TAB_STEP     = 17'd20 + 17'(GLYPH_COLS);
    localparam logic [12:0] RST_WIDTH    = 13'd640;
    localparam logic [12:0] RST_HEIGHT   = 13'd480;
    localparam logic [2:0]  RST_PIX      = 3'd4;
    localparam logic [3:0]  COLOUR_LAST  = 4'd8;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [2:0] {
        REG_PANEL_WIDTH   = 3'd0,
        REG_PANEL_HEIGHT  = 3'd1,
        REG_PIXEL_BYTES   = 3'd2,
        REG_COLOR_SELECT  = 3'd3,
        REG_XOR_MODE      = 3'd4,
        REG_ORIGIN_COLUMN = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } draw_state_t;

    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
        logic [3:0] glyph_row;
        logic [7:0] row_bits;
    } char_item_t;

    typedef struct packed {
        logic [15:0] row_y;
        logic [15:0] start_x;
        logic [7:0]  pixel_mask;
        logic [31:0] pixel_value;
        logic        xor_write;
        logic [31:0] byte_offset;
        logic        last_row;
    } pix_item_t;

    typedef struct packed {
        logic [12:0] panel_width;
        logic [12:0] panel_height;
        logic [2:0]  pixel_bytes;
        logic [3:0]  color_select;
        logic        xor_mode;
        logic [11:0] origin_column;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } ram_req_t;

    typedef struct packed {
        logic busy;
        logic pend_valid;
    } draw_status_t;

    function automatic logic [15:0] sat16(input logic [16:0] s);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic [31:0] colour_lut(input logic [3:0] sel);
        logic [31:0] c;
        case (sel)
            4'd1:    c = 32'hff0000ff;
            4'd2:    c = 32'h00ff00ff;
            4'd3:    c = 32'h0000ffff;
            4'd4:    c = 32'hffff00ff;
            4'd5:    c = 32'hff00ffff;
            4'd6:    c = 32'h00ffffff;
            4'd7:    c = 32'hffffffff;
            4'd8:    c = 32'h80000000;
            default: c = 32'h000000ff;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[src/bgtr_glyph_ram.sv]
// Glyph store: one shared address, synchronous write and registered read.
// Depends on bgtr_pkg for depth and the request struct.
`default_nettype none

module bgtr_glyph_ram
    import bgtr_pkg::*;
(
    input  wire logic     clk,
    input  wire ram_req_t req,
    output logic [7:0]    rdata
);

    logic [7:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.addr];
        end
    end

endmodule

`default_nettype wire

[src/bgtr_cfg_regs.sv]
// APB-style registers: panel, pixel, colour, XOR and cursor origin settings.
// Depends on bgtr_pkg for the register map and the cfg_t struct.
`default_nettype none

module bgtr_cfg_regs
    import bgtr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr;

    assign idx    = reg_index_t'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_PANEL_WIDTH:   cfg_next.panel_width   = pwdata[12:0];
                REG_PANEL_HEIGHT:  cfg_next.panel_height  = pwdata[12:0];
                REG_PIXEL_BYTES:   cfg_next.pixel_bytes   = pwdata[2:0];
                REG_COLOR_SELECT:
                begin
                    if (pwdata[3:0] <= COLOUR_LAST)
                    begin
                        cfg_next.color_select = pwdata[3:0];
                    end
                end
                REG_XOR_MODE:      cfg_next.xor_mode      = pwdata[0];
                REG_ORIGIN_COLUMN: cfg_next.origin_column = pwdata[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PANEL_WIDTH:   prdata = {19'd0, cfg_reg.panel_width};
            REG_PANEL_HEIGHT:  prdata = {19'd0, cfg_reg.panel_height};
            REG_PIXEL_BYTES:   prdata = {29'd0, cfg_reg.pixel_bytes};
            REG_COLOR_SELECT:  prdata = {28'd0, cfg_reg.color_select};
            REG_XOR_MODE:      prdata = {31'd0, cfg_reg.xor_mode};
            REG_ORIGIN_COLUMN: prdata = {20'd0, cfg_reg.origin_column};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width   <= RST_WIDTH;
            cfg_reg.panel_height  <= RST_HEIGHT;
            cfg_reg.pixel_bytes   <= RST_PIX;
            cfg_reg.color_select  <= 4'd0;
            cfg_reg.xor_mode      <= 1'b0;
            cfg_reg.origin_column <= 12'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[src/bgtr_draw.sv]
// Cursor control, row sequencer: glyph store writes/reads, builds row requests.
// Depends on bgtr_pkg; drives the bgtr_glyph_ram request port.
`default_nettype none

module bgtr_draw
    import bgtr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       char_valid,
    input  wire char_item_t char_item,
    output logic            char_stall,
    output logic            pix_valid,
    output pix_item_t       pix_item,
    input  wire logic       pix_stall,
    output ram_req_t        ram_req,
    input  wire logic [7:0] ram_rdata,
    output draw_status_t    status
);

    draw_state_t             state_reg, state_next;
    logic [15:0]             cur_x_reg, cur_x_next;
    logic [15:0]             cur_y_reg, cur_y_next;
    logic [15:0]             ctx_x_reg, ctx_x_next;
    logic [15:0]             ctx_y_reg, ctx_y_next;
    logic [ADDR_W-1:0]       ctx_base_reg, ctx_base_next;
    logic                    ctx_ok_reg, ctx_ok_next;
    logic [GLYPH_COLS-1:0]   col_mask_reg, col_mask_next;
    logic [LIN_W-1:0]        lin_reg, lin_next;
    logic [ROW_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [ROW_W-1:0]        em_idx_reg, em_idx_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    out_valid_reg, out_valid_next;
    pix_item_t               out_reg, out_next;

    logic                    busy;
    logic                    accept;
    logic                    wrap;
    logic                    issue;
    logic                    load_out;
    logic [28:0]             prod;
    logic [16:0]             line;
    logic [31:0]             colour;
    logic [1:0]              pix_shift;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = char_valid && !busy;
    assign char_stall = busy;
    assign pix_valid  = out_valid_reg;
    assign pix_item   = out_reg;
    assign status     = '{busy: busy, pend_valid: pend_valid_reg};

    assign wrap     = (17'(cur_x_reg) + 17'(GLYPH_COLS)) > 17'(cfg.panel_width);
    assign prod     = 29'(ctx_y_reg) * 29'(cfg.panel_width);
    assign line     = 17'(ctx_y_reg) + 17'(em_idx_reg);
    assign load_out = pend_valid_reg && (!out_valid_reg || !pix_stall);
    assign issue    = (state_reg == ST_RUN) && (rd_idx_reg < ROW_W'(GLYPH_ROWS))
                      && (!pend_valid_reg || load_out);

    always_comb
    begin
        case (cfg.pixel_bytes)
            3'd2:    pix_shift = 2'd1;
            3'd4:    pix_shift = 2'd2;
            default: pix_shift = 2'd0;
        endcase
        colour = colour_lut(cfg.color_select);
        case (pix_shift)
            2'd0:    colour = colour & 32'h000000ff;
            2'd1:    colour = colour & 32'h0000ffff;
            default: colour = colour;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        ctx_x_next      = ctx_x_reg;
        ctx_y_next      = ctx_y_reg;
        ctx_base_next   = ctx_base_reg;
        ctx_ok_next     = ctx_ok_reg;
        col_mask_next   = col_mask_reg;
        lin_next        = lin_reg;
        rd_idx_next     = rd_idx_reg;
        em_idx_next     = em_idx_reg;
        out_next        = out_reg;
        out_valid_next  = pix_stall ? out_valid_reg : 1'b0;
        pend_valid_next = issue ? 1'b1 : (load_out ? 1'b0 : pend_valid_reg);

        ram_req.we    = 1'b0;
        ram_req.re    = issue;
        ram_req.wdata = char_item.row_bits;
        ram_req.addr  = ctx_base_reg + ADDR_W'(rd_idx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && char_item.op == OP_LOAD)
                begin
                    ram_req.addr = ADDR_W'(ADDR_W'(char_item.char_code) * ADDR_W'(GLYPH_ROWS)
                                   + ADDR_W'(char_item.glyph_row));
                    ram_req.we   = ({1'b0, char_item.char_code} < 9'(CHAR_COUNT))
                                   && (6'(char_item.glyph_row) < 6'(GLYPH_ROWS));
                end
                else if (accept && char_item.char_code == CODE_NEWLINE)
                begin
                    cur_y_next = sat16(17'(cur_y_reg) + 17'(GLYPH_ROWS));
                    cur_x_next = 16'(cfg.origin_column);
                end
                else if (accept && char_item.char_code == CODE_TAB)
                begin
                    cur_x_next = sat16(17'(cur_x_reg) + TAB_STEP);
                end
                else if (accept)
                begin
                    ctx_x_next    = wrap ? 16'(cfg.origin_column) : cur_x_reg;
                    ctx_y_next    = wrap ? sat16(17'(cur_y_reg) + 17'(GLYPH_ROWS))
                                         : cur_y_reg;
                    ctx_base_next = ADDR_W'(ADDR_W'(char_item.char_code)
                                            * ADDR_W'(GLYPH_ROWS));
                    ctx_ok_next   = {1'b0, char_item.char_code} < 9'(CHAR_COUNT);
                    cur_x_next    = sat16(17'(ctx_x_next) + 17'(GLYPH_COLS));
                    cur_y_next    = ctx_y_next;
                    state_next    = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                lin_next = LIN_W'(prod) + LIN_W'(ctx_x_reg);
                for (int j = 0; j < GLYPH_COLS; j++)
                begin
                    col_mask_next[GLYPH_COLS-1-j] =
                        (17'(ctx_x_reg) + 17'(j)) < 17'(cfg.panel_width);
                end
                rd_idx_next = '0;
                em_idx_next = '0;
                state_next  = ST_RUN;
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + ROW_W'(1);
                end
                if (load_out)
                begin
                    out_valid_next       = 1'b1;
                    out_next.row_y       = line[15:0];
                    out_next.start_x     = ctx_x_reg;
                    out_next.pixel_mask  = (ctx_ok_reg && line < 17'(cfg.panel_height))
                                           ? (ram_rdata & col_mask_reg) : 8'd0;
                    out_next.pixel_value = colour;
                    out_next.xor_write   = cfg.xor_mode;
                    out_next.byte_offset = 32'({2'b00, lin_reg} << pix_shift);
                    out_next.last_row    = (em_idx_reg == ROW_W'(GLYPH_ROWS - 1));
                    lin_next             = lin_reg + LIN_W'(cfg.panel_width);
                    em_idx_next          = em_idx_reg + ROW_W'(1);
                    if (em_idx_reg == ROW_W'(GLYPH_ROWS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_x_reg      <= 16'd0;
            cur_y_reg      <= 16'd0;
            rd_idx_reg     <= '0;
            em_idx_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            rd_idx_reg     <= rd_idx_next;
            em_idx_reg     <= em_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_x_reg    <= ctx_x_next;
        ctx_y_reg    <= ctx_y_next;
        ctx_base_reg <= ctx_base_next;
        ctx_ok_reg   <= ctx_ok_next;
        col_mask_reg <= col_mask_next;
        lin_reg      <= lin_next;
        out_reg      <= out_next;
    end

endmodule

`default_nettype wire

[src/bitmap_glyph_text_renderer_top.sv]
// The first row request of a printing character leaves after the accept, ST_SETUP,
// the glyph store read in ST_RUN and the registered output. A printing character
// holds the input through setup, the first glyph store read, then one row a cycle
// while pix_stall is low, through the single store read port. Load, newline and
// tab leave the input open and emit nothing. Reset clears the cursor and loads the
// register defaults; the glyph store holds undefined contents until written.
`default_nettype none

module bitmap_glyph_text_renderer_top
    import bgtr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               char_valid,
    input  wire char_item_t         char_item,
    output logic                    char_stall,
    output logic                    pix_valid,
    output pix_item_t               pix_item,
    input  wire logic               pix_stall
);

    cfg_t         cfg;
    ram_req_t     ram_req;
    logic [7:0]   ram_rdata;
    draw_status_t status;

    bgtr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bgtr_glyph_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    bgtr_draw u_draw (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .char_valid (char_valid),
        .char_item  (char_item),
        .char_stall (char_stall),
        .pix_valid  (pix_valid),
        .pix_item   (pix_item),
        .pix_stall  (pix_stall),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .status     (status)
    );

    assert property (@(posedge clk) disable iff (!rst_n) ram_req.we |-> !ram_req.re)
        else $error("glyph store written and read in the same cycle");

    assert property (@(posedge clk) disable iff (!rst_n) status.pend_valid |-> status.busy)
        else $error("glyph row pending while sequencer idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && !pix_stall && !pix_item.last_row) |-> char_stall)
        else $error("input open before the last row of a character");

    assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && !char_stall && char_item.op == OP_LOAD) |-> !status.pend_valid)
        else $error("load taken while a glyph read is outstanding");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for bitmap_glyph_text_renderer_top: glyph loads and text draw requests
// under random idling, register phases over APB, rows checked against a cursor/store model.
// Depends on bgtr_pkg and the renderer RTL under src.

module tb;
    import bgtr_pkg::*;

    localparam int TAB_ADVANCE     = 20 + GLYPH_COLS;
    localparam int CURSOR_TOP      = 65535;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER_ROWS = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int REPORT_MAX      = 10;
    localparam logic [7:0] CODE_TOP = 8'(CHAR_COUNT - 1);

    localparam logic [8:0][31:0] PALETTE = {
        32'h80000000, 32'hffffffff, 32'h00ffffff, 32'hff00ffff, 32'hffff00ff,
        32'h0000ffff, 32'h00ff00ff, 32'hff0000ff, 32'h000000ff
    };
    localparam logic [15:0][7:0] TEST_ROWS = {
        8'hdb, 8'h24, 8'he7, 8'h18, 8'h3c, 8'hc3, 8'h7e, 8'h81,
        8'h0f, 8'hf0, 8'h55, 8'haa, 8'h01, 8'h80, 8'hff, 8'h00
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               char_valid = 1'b0;
    char_item_t         char_item = '0;
    logic               char_stall;
    logic               pix_valid;
    pix_item_t          pix_item;
    logic               pix_stall = 1'b0;

    // renderer state as seen by the checker
    int unsigned cfg_width = RST_WIDTH;
    int unsigned cfg_height = RST_HEIGHT;
    int unsigned cfg_bytes = RST_PIX;
    int unsigned cfg_colour = 0;
    int unsigned cfg_xor = 0;
    int unsigned cfg_origin = 0;
    int unsigned pen_x = 0;
    int unsigned pen_y = 0;
    logic [7:0]  glyph_mem [CHAR_COUNT * GLYPH_ROWS];

    pix_item_t  rows_due [$];
    char_item_t pending [$];

    bit [GLYPH_ROWS-1:0] rows_loaded [CHAR_COUNT];
    bit                  is_drawable [CHAR_COUNT];
    int                  drawable [$];

    int items_queued = 0;
    int loads_taken = 0;
    int draws_taken = 0;
    int rows_checked = 0;
    int mismatches = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    int send_wait = 0;
    int send_run = 0;
    bit send_calm = 1'b0;
    int recv_wait = 0;
    int recv_run = 0;
    bit recv_calm = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    pix_item_t want;

    bitmap_glyph_text_renderer_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .char_valid (char_valid),
        .char_item  (char_item),
        .char_stall (char_stall),
        .pix_valid  (pix_valid),
        .pix_item   (pix_item),
        .pix_stall  (pix_stall)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned clamp_add(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > CURSOR_TOP) ? CURSOR_TOP : s;
    endfunction

    function automatic string row_text(input pix_item_t r);
        return $sformatf("y=%0d x=%0d mask=%02h value=%08h xor=%b offset=%08h last=%b",
                         r.row_y, r.start_x, r.pixel_mask, r.pixel_value, r.xor_write,
                         r.byte_offset, r.last_row);
    endfunction

    task automatic render_request(input char_item_t req);
        int unsigned pb;
        int unsigned line;
        logic [31:0] colour;
        logic [7:0]  glyph;
        logic [7:0]  mask;
        logic [63:0] offset;
        pix_item_t   row;
        if (req.op == OP_LOAD)
        begin
            loads_taken++;
            if (int'(req.char_code) < CHAR_COUNT && int'(req.glyph_row) < GLYPH_ROWS)
                glyph_mem[int'(req.char_code) * GLYPH_ROWS + int'(req.glyph_row)] = req.row_bits;
            return;
        end
        draws_taken++;
        if (req.char_code == CODE_NEWLINE)
        begin
            pen_y = clamp_add(pen_y, GLYPH_ROWS);
            pen_x = cfg_origin;
            return;
        end
        if (req.char_code == CODE_TAB)
        begin
            pen_x = clamp_add(pen_x, TAB_ADVANCE);
            return;
        end
        if (pen_x + GLYPH_COLS > cfg_width)
        begin
            pen_x = cfg_origin;
            pen_y = clamp_add(pen_y, GLYPH_ROWS);
        end
        pb = (cfg_bytes == 2 || cfg_bytes == 4) ? cfg_bytes : 1;
        colour = PALETTE[cfg_colour];
        if (pb == 1)
            colour = colour & 32'h0000_00ff;
        else if (pb == 2)
            colour = colour & 32'h0000_ffff;
        for (int i = 0; i < GLYPH_ROWS; i++)
        begin
            line = pen_y + i;
            glyph = 8'h00;
            if (int'(req.char_code) < CHAR_COUNT)
                glyph = glyph_mem[int'(req.char_code) * GLYPH_ROWS + i];
            mask = 8'h00;
            if (line < cfg_height)
                for (int j = 0; j < GLYPH_COLS; j++)
                    if (glyph[7 - j] && pen_x + j < cfg_width)
                        mask[7 - j] = 1'b1;
            offset = (64'(line) * 64'(cfg_width) + 64'(pen_x)) * 64'(pb);
            row.row_y       = 16'(line);
            row.start_x     = 16'(pen_x);
            row.pixel_mask  = mask;
            row.pixel_value = colour;
            row.xor_write   = cfg_xor[0];
            row.byte_offset = offset[31:0];
            row.last_row    = (i == GLYPH_ROWS - 1);
            rows_due.push_back(row);
        end
        pen_x = clamp_add(pen_x, GLYPH_COLS);
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PANEL_WIDTH:   cfg_width = value[12:0];
            REG_PANEL_HEIGHT:  cfg_height = value[12:0];
            REG_PIXEL_BYTES:   cfg_bytes = value[2:0];
            REG_COLOR_SELECT:  if (value[3:0] <= COLOUR_LAST) cfg_colour = value[3:0];
            REG_XOR_MODE:      cfg_xor = value[0];
            REG_ORIGIN_COLUMN: cfg_origin = value[11:0];
            default:           ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned w, input int unsigned h,
                                 input int unsigned pb, input int unsigned colour,
                                 input int unsigned xr, input int unsigned origin);
        reg_write(REG_PANEL_WIDTH, w);
        reg_write(REG_PANEL_HEIGHT, h);
        reg_write(REG_PIXEL_BYTES, pb);
        reg_write(REG_COLOR_SELECT, colour);
        reg_write(REG_XOR_MODE, xr);
        reg_write(REG_ORIGIN_COLUMN, origin);
        settings_used++;
    endtask

    task automatic drain();
        while (pending.size() != 0 || char_valid || rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_item(input logic op, input logic [7:0] code,
                              input logic [3:0] grow, input logic [7:0] bits);
        char_item_t it;
        it.op        = op;
        it.char_code = code;
        it.glyph_row = grow;
        it.row_bits  = bits;
        pending.push_back(it);
        items_queued++;
        if (op == OP_LOAD)
        begin
            rows_loaded[code][grow] = 1'b1;
            if (&rows_loaded[code] && !is_drawable[code])
            begin
                is_drawable[code] = 1'b1;
                drawable.push_back(int'(code));
            end
        end
    endtask

    task automatic queue_draw(input logic [7:0] code);
        queue_item(OP_DRAW, code, 4'($urandom), 8'($urandom));
    endtask

    task automatic queue_glyph(input logic [7:0] code);
        for (int r = 0; r < GLYPH_ROWS; r++)
            queue_item(OP_LOAD, code, 4'(r), 8'($urandom));
    endtask

    task automatic queue_random(input int count);
        int stop;
        int pick;
        int len;
        stop = items_queued + count;
        while (items_queued < stop)
        begin
            pick = $urandom_range(0, 9);
            if (drawable.size() == 0 || pick == 0)
                queue_glyph(8'($urandom_range(0, CHAR_COUNT - 1)));
            else if (pick <= 7)
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        queue_draw(CODE_NEWLINE);
                    else if (pick == 1)
                        queue_draw(CODE_TAB);
                    else
                        queue_draw(8'(drawable[$urandom_range(0, drawable.size() - 1)]));
                end
            end
            else if (pick == 8)
                queue_item(OP_LOAD, 8'($urandom), 4'($urandom), 8'($urandom));
            else
                queue_draw($urandom_range(0, 1) ? CODE_NEWLINE : CODE_TAB);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_item  <= '0;
            send_wait = 0;
        end
        else if (!(char_valid && char_stall))
        begin
            if (char_valid)
                render_request(char_item);
            if (send_wait > 0)
            begin
                send_wait--;
                char_valid <= 1'b0;
            end
            else if (pending.size() != 0)
            begin
                char_item  <= pending.pop_front();
                char_valid <= 1'b1;
                if (send_run == 0)
                begin
                    send_run = $urandom_range(8, 40);
                    send_calm = ($urandom_range(0, 2) == 0);
                end
                send_run--;
                send_wait = send_calm ? 0 : $urandom_range(0, 6);
            end
            else
                char_valid <= 1'b0;
        end
    end

    // row monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_stall <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (pix_valid && !pix_stall)
            begin
                rows_checked++;
                if (rows_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected row: %s", row_text(pix_item));
                end
                else
                begin
                    want = rows_due.pop_front();
                    if (pix_item.row_y !== want.row_y || pix_item.start_x !== want.start_x ||
                        pix_item.pixel_mask !== want.pixel_mask ||
                        pix_item.pixel_value !== want.pixel_value ||
                        pix_item.xor_write !== want.xor_write ||
                        pix_item.byte_offset !== want.byte_offset ||
                        pix_item.last_row !== want.last_row)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("row mismatch at %0t", $time);
                            $display("  expected %s", row_text(want));
                            $display("  actual   %s", row_text(pix_item));
                        end
                    end
                end
                if (recv_run == 0)
                begin
                    recv_run = $urandom_range(8, 40);
                    recv_calm = ($urandom_range(0, 2) == 0);
                end
                recv_run--;
                recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
            end
            if (!hold_done && rows_checked >= HOLD_AFTER_ROWS)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_stall <= 1'b1;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                pix_stall <= 1'b1;
            end
            else
                pix_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (pix_valid && !pix_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // narrow, short panel: wrap onto a clipped right edge, partial vertical clip
        apply_setting(21, 20, 2, 8, 1, 17);
        for (int r = 0; r < GLYPH_ROWS; r++)
            queue_item(OP_LOAD, CODE_TOP, 4'(r), TEST_ROWS[r]);
        queue_item(OP_LOAD, 8'h00, 4'h0, 8'h00);
        queue_draw(CODE_TOP);
        queue_draw(CODE_TOP);
        queue_draw(CODE_TOP);
        queue_draw(CODE_NEWLINE);
        queue_draw(CODE_TAB);
        queue_draw(CODE_TOP);
        drain();

        apply_setting(640, 480, 4, 7, 0, 0);
        queue_random(60);
        drain();

        apply_setting(1, 1, 1, 0, 0, 0);
        reg_write(REG_COLOR_SELECT, 9);
        queue_random(50);
        drain();

        apply_setting(4096, 4096, 3, 5, 1, 4095);
        queue_random(50);
        drain();

        apply_setting(8191, 0, 0, 12, 1, 100);
        queue_random(30);
        drain();

        apply_setting(0, 4096, 2, 6, 0, 0);
        queue_random(20);
        drain();

        apply_setting($urandom_range(8, 200), $urandom_range(1, 300), $urandom_range(0, 7),
                      $urandom_range(0, 8), $urandom_range(0, 1), $urandom_range(0, 200));
        reg_write(REG_COLOR_SELECT, 15);
        queue_random(60);
        drain();

        // wide panel: tab run from a far origin, then further lines down
        apply_setting(8191, 8191, 4, 1, 0, 4095);
        queue_draw(CODE_NEWLINE);
        repeat (8) queue_draw(CODE_TAB);
        queue_draw(CODE_TOP);
        repeat (4) queue_draw(CODE_NEWLINE);
        queue_draw(CODE_TOP);
        queue_draw(CODE_TOP);
        drain();

        $display("Run took %0d requests (%0d glyph row loads, %0d draws) over %0d settings,",
                 loads_taken + draws_taken, loads_taken, draws_taken, settings_used);
        $display("checked %0d rows with %0d mismatches.", rows_checked, mismatches);
        if (mismatches == 0 && rows_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
